// ===== hdl/dtp_pkg.sv =====
package dtp_pkg;

    // Default field widths
    localparam int DISPARITY_BITS_DEFAULT = 8;
    localparam int COORD_BITS_DEFAULT     = 12;

    // Fixed widths of the data path
    localparam int DEPTH_BITS  = 24;
    localparam int CENTER_BITS = 20;
    localparam int RECIP_BITS  = 24;
    localparam int POINT_BITS  = 32;
    localparam int COLOR_BITS  = 8;
    localparam int CUTOFF_BITS = 32;
    localparam int WORD_BITS   = 32;

    // Divider: quotient bits resolved per stage, and the stage count
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = DEPTH_BITS / DIV_STEPS;

    // Projection stages: multiply, split multiply, combine and saturate
    localparam int PROJ_STAGES = 3;

    // Configuration port
    localparam int ADDR_BITS      = 5;
    localparam int REG_INDEX_BITS = 3;

    localparam logic [REG_INDEX_BITS-1:0] REG_DEPTH_NUMERATOR = 3'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_CENTER_X        = 3'd1;
    localparam logic [REG_INDEX_BITS-1:0] REG_CENTER_Y        = 3'd2;
    localparam logic [REG_INDEX_BITS-1:0] REG_RECIP_FOCAL_X   = 3'd3;
    localparam logic [REG_INDEX_BITS-1:0] REG_RECIP_FOCAL_Y   = 3'd4;
    localparam logic [REG_INDEX_BITS-1:0] REG_Y_CUTOFF        = 3'd5;

    localparam logic [DEPTH_BITS-1:0]         RESET_DEPTH_NUMERATOR = 24'd322944;
    localparam logic [CENTER_BITS-1:0]        RESET_CENTER_X        = 20'd249917;
    localparam logic [CENTER_BITS-1:0]        RESET_CENTER_Y        = 20'd135831;
    localparam logic [RECIP_BITS-1:0]         RESET_RECIP_FOCAL_X   = 24'd13299;
    localparam logic [RECIP_BITS-1:0]         RESET_RECIP_FOCAL_Y   = 24'd14627;
    localparam logic signed [CUTOFF_BITS-1:0] RESET_Y_CUTOFF        = -32'sd17920;

endpackage

// ===== hdl/dtp_divider.sv =====
module dtp_divider #(
    parameter int DISPARITY_BITS = dtp_pkg::DISPARITY_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic [dtp_pkg::DIV_STAGES-1:0]    en,
    input  logic [DISPARITY_BITS-1:0]         divisor,
    input  logic [dtp_pkg::DEPTH_BITS-1:0]    numerator,
    output logic [dtp_pkg::DEPTH_BITS-1:0]    quotient
);

    localparam int STAGES = dtp_pkg::DIV_STAGES;
    localparam int STEPS  = dtp_pkg::DIV_STEPS;
    localparam int QB     = dtp_pkg::DEPTH_BITS;

    logic [DISPARITY_BITS-1:0] rem_reg  [STAGES];
    logic [DISPARITY_BITS-1:0] rem_next [STAGES];
    logic [DISPARITY_BITS-1:0] disp_reg [STAGES];
    logic [DISPARITY_BITS-1:0] disp_next[STAGES];
    logic [QB-1:0]             quot_reg [STAGES];
    logic [QB-1:0]             quot_next[STAGES];

    // Restoring division, STEPS quotient bits per stage, MSB first.
    // User must hold numerator still while items are in flight; unchecked.
    always_comb
    begin
        logic [DISPARITY_BITS-1:0] r;
        logic [DISPARITY_BITS:0]   t;
        logic [QB-1:0]             q;
        logic [DISPARITY_BITS-1:0] d;
        for (int s = 0; s < STAGES; s++)
        begin
            if (s == 0)
            begin
                r = '0;
                q = '0;
                d = divisor;
            end
            else
            begin
                r = rem_reg[s == 0 ? 0 : s - 1];
                q = quot_reg[s == 0 ? 0 : s - 1];
                d = disp_reg[s == 0 ? 0 : s - 1];
            end
            for (int k = 0; k < STEPS; k++)
            begin
                t = {r, numerator[QB - 1 - s * STEPS - k]};
                if (t >= {1'b0, d})
                begin
                    t = t - {1'b0, d};
                    q = {q[QB-2:0], 1'b1};
                end
                else
                begin
                    q = {q[QB-2:0], 1'b0};
                end
                r = t[DISPARITY_BITS-1:0];
            end
            rem_next[s]  = r;
            quot_next[s] = q;
            disp_next[s] = d;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            if (en[s])
            begin
                rem_reg[s]  <= rem_next[s];
                quot_reg[s] <= quot_next[s];
                disp_reg[s] <= disp_next[s];
            end
        end
    end

    assign quotient = quot_reg[STAGES-1];

endmodule

// ===== hdl/dtp_project.sv =====
module dtp_project #(
    parameter int COORD_BITS = dtp_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic [dtp_pkg::PROJ_STAGES-1:0]       en,
    input  logic [((COORD_BITS + 8 > dtp_pkg::CENTER_BITS) ?
                   (COORD_BITS + 8) : dtp_pkg::CENTER_BITS)-1:0] mag,
    input  logic                                  neg,
    input  logic [dtp_pkg::DEPTH_BITS-1:0]        z,
    input  logic [dtp_pkg::RECIP_BITS-1:0]        recip,
    output logic signed [dtp_pkg::POINT_BITS-1:0] coord
);

    localparam int MAG_BITS  = (COORD_BITS + 8 > dtp_pkg::CENTER_BITS) ?
                               (COORD_BITS + 8) : dtp_pkg::CENTER_BITS;
    localparam int WB        = dtp_pkg::WORD_BITS;
    localparam int RB        = dtp_pkg::RECIP_BITS;
    localparam int PROD_BITS = MAG_BITS + dtp_pkg::DEPTH_BITS;
    localparam int PH_BITS   = PROD_BITS - WB;
    localparam int HI_BITS   = PH_BITS + RB;
    localparam int LO_BITS   = WB + RB;
    localparam int Q_BITS    = HI_BITS + 1;
    localparam int PB        = dtp_pkg::POINT_BITS;

    logic [PROD_BITS-1:0] p_reg;
    logic [PROD_BITS-1:0] p_next;
    logic                 neg1_reg;
    logic [HI_BITS-1:0]   hi_reg;
    logic [HI_BITS-1:0]   hi_next;
    logic [LO_BITS-1:0]   lo_next;
    logic [RB-1:0]        lo_hi_reg;
    logic                 lo_nz_reg;
    logic                 neg2_reg;
    logic [Q_BITS-1:0]    q_next;
    logic [PB-1:0]        coord_next;
    logic [PB-1:0]        coord_reg;

    // Stage 1: magnitude times depth
    assign p_next = PROD_BITS'(mag) * PROD_BITS'(z);

    // Stage 2: split product times reciprocal focal length
    assign hi_next = HI_BITS'(p_reg[PROD_BITS-1:WB]) * HI_BITS'(recip);
    assign lo_next = LO_BITS'(p_reg[WB-1:0]) * LO_BITS'(recip);

    // Stage 3: combine, round toward minus infinity on negatives, saturate
    always_comb
    begin
        q_next = Q_BITS'(hi_reg) + Q_BITS'(lo_hi_reg) + Q_BITS'(neg2_reg && lo_nz_reg);
        if (neg2_reg)
        begin
            if ((|q_next[Q_BITS-1:PB]) || (q_next[PB-1] && (|q_next[PB-2:0])))
                coord_next = {1'b1, {(PB-1){1'b0}}};
            else
                coord_next = -q_next[PB-1:0];
        end
        else
        begin
            if (|q_next[Q_BITS-1:PB-1])
                coord_next = {1'b0, {(PB-1){1'b1}}};
            else
                coord_next = q_next[PB-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_reg    <= p_next;
            neg1_reg <= neg;
        end
        if (en[1])
        begin
            hi_reg    <= hi_next;
            lo_hi_reg <= lo_next[LO_BITS-1:WB];
            lo_nz_reg <= |lo_next[WB-1:0];
            neg2_reg  <= neg1_reg;
        end
        if (en[2])
        begin
            coord_reg <= coord_next;
        end
    end

    assign coord = $signed(coord_reg);

endmodule

// ===== hdl/disparity_to_point_backprojection.sv =====
// An accepted input passes the divider stages, projection stages and output register.
// Throughput: one transaction per cycle; every stage holds its own valid bit, so a
// stalled output only backs up the stages that are full and bubbles still close up.
// Reset (rst_n low, asynchronous) clears all valid bits and loads the default
// camera constants into the configuration registers; data registers are not reset.
module disparity_to_point_backprojection #(
    parameter int DISPARITY_BITS = dtp_pkg::DISPARITY_BITS_DEFAULT,
    parameter int COORD_BITS     = dtp_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    // APB-style configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [dtp_pkg::ADDR_BITS-1:0]         paddr,
    input  logic [dtp_pkg::WORD_BITS-1:0]         pwdata,
    output logic [dtp_pkg::WORD_BITS-1:0]         prdata,
    output logic                                  pready,

    // Pixel input channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [COORD_BITS-1:0]                 pixel_row,
    input  logic [COORD_BITS-1:0]                 pixel_column,
    input  logic [DISPARITY_BITS-1:0]             disparity,
    input  logic [dtp_pkg::COLOR_BITS-1:0]        blue,
    input  logic [dtp_pkg::COLOR_BITS-1:0]        green,
    input  logic [dtp_pkg::COLOR_BITS-1:0]        red,

    // Point output channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [dtp_pkg::POINT_BITS-1:0] point_x,
    output logic signed [dtp_pkg::POINT_BITS-1:0] point_y,
    output logic [dtp_pkg::DEPTH_BITS-1:0]        point_z,
    output logic                                  point_valid,
    output logic [dtp_pkg::COLOR_BITS-1:0]        out_blue,
    output logic [dtp_pkg::COLOR_BITS-1:0]        out_green,
    output logic [dtp_pkg::COLOR_BITS-1:0]        out_red
);

    localparam int DIV_STAGES  = dtp_pkg::DIV_STAGES;
    localparam int PROJ_STAGES = dtp_pkg::PROJ_STAGES;
    // Divider stages, projection stages, then the output register
    localparam int STAGES      = DIV_STAGES + PROJ_STAGES + 1;
    localparam int MAG_BITS    = (COORD_BITS + 8 > dtp_pkg::CENTER_BITS) ?
                                 (COORD_BITS + 8) : dtp_pkg::CENTER_BITS;
    localparam int CB          = dtp_pkg::CENTER_BITS;
    localparam int DB          = dtp_pkg::DEPTH_BITS;
    localparam int RB          = dtp_pkg::RECIP_BITS;
    localparam int PB          = dtp_pkg::POINT_BITS;
    localparam int WB          = dtp_pkg::WORD_BITS;
    localparam int XB          = dtp_pkg::COLOR_BITS;

    // Side data that rides along the pipeline next to the arithmetic
    typedef struct packed {
        logic [XB-1:0]       blue;
        logic [XB-1:0]       green;
        logic [XB-1:0]       red;
        logic                dnz;
        logic [MAG_BITS-1:0] mag_x;
        logic [MAG_BITS-1:0] mag_y;
        logic                neg_x;
        logic                neg_y;
        logic [DB-1:0]       z;
    } side_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DB-1:0]        depth_numerator_reg;
    logic [CB-1:0]        center_x_reg;
    logic [CB-1:0]        center_y_reg;
    logic [RB-1:0]        recip_focal_x_reg;
    logic [RB-1:0]        recip_focal_y_reg;
    logic signed [PB-1:0] y_cutoff_reg;

    logic                               cfg_write;
    logic [dtp_pkg::REG_INDEX_BITS-1:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[dtp_pkg::ADDR_BITS-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_numerator_reg <= dtp_pkg::RESET_DEPTH_NUMERATOR;
            center_x_reg        <= dtp_pkg::RESET_CENTER_X;
            center_y_reg        <= dtp_pkg::RESET_CENTER_Y;
            recip_focal_x_reg   <= dtp_pkg::RESET_RECIP_FOCAL_X;
            recip_focal_y_reg   <= dtp_pkg::RESET_RECIP_FOCAL_Y;
            y_cutoff_reg        <= dtp_pkg::RESET_Y_CUTOFF;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dtp_pkg::REG_DEPTH_NUMERATOR: depth_numerator_reg <= pwdata[DB-1:0];
                dtp_pkg::REG_CENTER_X:        center_x_reg        <= pwdata[CB-1:0];
                dtp_pkg::REG_CENTER_Y:        center_y_reg        <= pwdata[CB-1:0];
                dtp_pkg::REG_RECIP_FOCAL_X:   recip_focal_x_reg   <= pwdata[RB-1:0];
                dtp_pkg::REG_RECIP_FOCAL_Y:   recip_focal_y_reg   <= pwdata[RB-1:0];
                dtp_pkg::REG_Y_CUTOFF:        y_cutoff_reg        <= $signed(pwdata[PB-1:0]);
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // Read back, zero-extended
    always_comb
    begin
        unique case (cfg_index)
            dtp_pkg::REG_DEPTH_NUMERATOR: prdata = WB'(depth_numerator_reg);
            dtp_pkg::REG_CENTER_X:        prdata = WB'(center_x_reg);
            dtp_pkg::REG_CENTER_Y:        prdata = WB'(center_y_reg);
            dtp_pkg::REG_RECIP_FOCAL_X:   prdata = WB'(recip_focal_x_reg);
            dtp_pkg::REG_RECIP_FOCAL_Y:   prdata = WB'(recip_focal_y_reg);
            dtp_pkg::REG_Y_CUTOFF:        prdata = WB'(y_cutoff_reg);
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    // A stage advances when it is empty or when the stage after it advances.
    // The last stage is the output register and advances on out_ready.
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] en;

    always_comb
    begin
        en[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
            en[i] = !valid_reg[i] || en[i+1];
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
                valid_reg[0] <= in_valid;
            for (int i = 1; i < STAGES; i++)
            begin
                if (en[i])
                    valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: offsets from the principal point, in sign and magnitude.
    // These run beside the first divider stage.
    // ------------------------------------------------------------------
    logic [MAG_BITS:0] diff_x;
    logic [MAG_BITS:0] diff_y;
    side_t             side_in;

    always_comb
    begin
        diff_x = (MAG_BITS + 1)'({pixel_column, 8'h00}) - (MAG_BITS + 1)'(center_x_reg);
        diff_y = (MAG_BITS + 1)'({pixel_row, 8'h00}) - (MAG_BITS + 1)'(center_y_reg);

        side_in.blue  = blue;
        side_in.green = green;
        side_in.red   = red;
        side_in.dnz   = |disparity;
        side_in.neg_x = diff_x[MAG_BITS];
        side_in.neg_y = diff_y[MAG_BITS];
        side_in.mag_x = diff_x[MAG_BITS] ? MAG_BITS'(-diff_x) : diff_x[MAG_BITS-1:0];
        side_in.mag_y = diff_y[MAG_BITS] ? MAG_BITS'(-diff_y) : diff_y[MAG_BITS-1:0];
        side_in.z     = '0;
    end

    // ------------------------------------------------------------------
    // Side data registers for every stage but the output register
    // ------------------------------------------------------------------
    side_t         side_reg [STAGES-1];
    side_t         side_next[STAGES-1];
    logic [DB-1:0] quotient;

    always_comb
    begin
        side_next[0] = side_in;
        for (int i = 1; i < STAGES - 1; i++)
        begin
            side_next[i] = side_reg[i-1];
            // Latch depth as it leaves the divider
            if (i == DIV_STAGES)
                side_next[i].z = quotient;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STAGES - 1; i++)
        begin
            if (en[i])
                side_reg[i] <= side_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Depth: depth_numerator / disparity, DIV_STEPS (four) quotient bits per stage
    // ------------------------------------------------------------------
    dtp_divider #(
        .DISPARITY_BITS (DISPARITY_BITS)
    ) u_divider (
        .clk       (clk),
        .en        (en[DIV_STAGES-1:0]),
        .divisor   (disparity),
        .numerator (depth_numerator_reg),
        .quotient  (quotient)
    );

    // ------------------------------------------------------------------
    // X and Y projections; both consume depth straight from the divider
    // ------------------------------------------------------------------
    logic signed [PB-1:0] proj_x;
    logic signed [PB-1:0] proj_y;

    dtp_project #(
        .COORD_BITS (COORD_BITS)
    ) u_project_x (
        .clk   (clk),
        .en    (en[DIV_STAGES+PROJ_STAGES-1:DIV_STAGES]),
        .mag   (side_reg[DIV_STAGES-1].mag_x),
        .neg   (side_reg[DIV_STAGES-1].neg_x),
        .z     (quotient),
        .recip (recip_focal_x_reg),
        .coord (proj_x)
    );

    dtp_project #(
        .COORD_BITS (COORD_BITS)
    ) u_project_y (
        .clk   (clk),
        .en    (en[DIV_STAGES+PROJ_STAGES-1:DIV_STAGES]),
        .mag   (side_reg[DIV_STAGES-1].mag_y),
        .neg   (side_reg[DIV_STAGES-1].neg_y),
        .z     (quotient),
        .recip (recip_focal_y_reg),
        .coord (proj_y)
    );

    // ------------------------------------------------------------------
    // Output stage: no-measurement and cut-off tests, then the result register.
    // With no measurement the cut-off test sees Y = 0. Either case zeroes
    // all three coordinates; the colour always passes through.
    // ------------------------------------------------------------------
    side_t                side_last;
    logic signed [PB-1:0] y_test;
    logic                 keep;

    logic signed [PB-1:0] point_x_reg;
    logic signed [PB-1:0] point_y_reg;
    logic [DB-1:0]        point_z_reg;
    logic                 point_valid_reg;
    logic [XB-1:0]        out_blue_reg;
    logic [XB-1:0]        out_green_reg;
    logic [XB-1:0]        out_red_reg;

    assign side_last = side_reg[STAGES-2];
    assign y_test    = side_last.dnz ? proj_y : '0;
    assign keep      = side_last.dnz && !(y_test < y_cutoff_reg);

    always_ff @(posedge clk)
    begin
        if (en[STAGES-1])
        begin
            point_x_reg     <= keep ? proj_x : '0;
            point_y_reg     <= keep ? proj_y : '0;
            point_z_reg     <= keep ? side_last.z : '0;
            point_valid_reg <= keep;
            out_blue_reg    <= side_last.blue;
            out_green_reg   <= side_last.green;
            out_red_reg     <= side_last.red;
        end
    end

    assign point_x     = point_x_reg;
    assign point_y     = point_y_reg;
    assign point_z     = point_z_reg;
    assign point_valid = point_valid_reg;
    assign out_blue    = out_blue_reg;
    assign out_green   = out_green_reg;
    assign out_red     = out_red_reg;

endmodule
